// File: hw/rtl/assert_macros.svh
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every rising clock edge outside reset.
`define ASSERT_PROP(lbl, clk, rst, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) \
    else $error("assertion failed");

// Condition must never be true outside reset.
`define ASSERT_NEVER(lbl, clk, rst, cond) \
  lbl: assert property (@(posedge clk) disable iff (rst) !(cond)) \
    else $error("forbidden condition seen");

`endif

// File: hw/rtl/escu_pkg.sv
package escu_pkg;

  localparam int IN_W   = 56;
  localparam int OUT_W  = 56;
  localparam int CFG_AW = 6;
  localparam int CFG_DW = 64;

  localparam int MUL_LAT   = 2;
  localparam int DIV_STEPS = 64;
  localparam int DIV_LAT   = DIV_STEPS + 2;

  localparam longint unsigned P_TFINE_OFS  = 128000;
  localparam longint unsigned P_ADC_FS     = 1048576;
  localparam longint unsigned P_SCALE      = 3125;
  localparam longint unsigned P_ONE_47     = 64'h0000_8000_0000_0000;
  localparam int unsigned     H_TFINE_OFS  = 76800;
  localparam int unsigned     H_RND_A      = 16384;
  localparam int unsigned     H_RND_B      = 32768;
  localparam int unsigned     H_OFS_B      = 2097152;
  localparam int unsigned     H_RND_C      = 8192;
  localparam int unsigned     H_MAX        = 419430400;
  localparam int              T_MIN        = -4000;
  localparam int              T_MAX        = 8500;

  typedef enum logic [2:0] {
    REG_TEMP     = 3'd0,
    REG_PRESS_A  = 3'd1,
    REG_PRESS_B  = 3'd2,
    REG_PRESS_P9 = 3'd3,
    REG_HUM      = 3'd4
  } escu_reg_t;

  typedef struct packed {
    logic [47:0] temp;
    logic [63:0] press_a;
    logic [63:0] press_b;
    logic [15:0] p9;
    logic [63:0] hum;
  } escu_calib_t;

endpackage

// File: hw/rtl/escu_dly.sv
module escu_dly #(
  parameter int W     = 32,
  parameter int DEPTH = 2
) (
  input  logic         clk,
  input  logic         ce,
  input  logic [W-1:0] d,
  output logic [W-1:0] q
);

  logic [W-1:0] sr [DEPTH];

  always_ff @(posedge clk) begin
    if (ce) begin
      sr[0] <= d;
      for (int i = 1; i < DEPTH; i++) begin
        sr[i] <= sr[i-1];
      end
    end
  end

  assign q = sr[DEPTH-1];

endmodule

// File: hw/rtl/escu_mul64.sv
// 64 x 64 product modulo 2^64, two stages.
module escu_mul64 (
  input  logic        clk,
  input  logic        ce,
  input  logic [63:0] a,
  input  logic [63:0] b,
  output logic [63:0] y
);

  logic [63:0] ll;
  logic [31:0] lh;
  logic [31:0] hl;

  always_ff @(posedge clk) begin
    if (ce) begin
      ll <= 64'(a[31:0]) * 64'(b[31:0]);
      lh <= a[31:0] * b[63:32];
      hl <= a[63:32] * b[31:0];
      y  <= ll + {lh + hl, 32'd0};
    end
  end

endmodule

// File: hw/rtl/escu_sdiv.sv
// Signed 64 / 32-bit division, truncating, one quotient bit per stage.
module escu_sdiv (
  input  logic        clk,
  input  logic        ce,
  input  logic [63:0] num,
  input  logic [31:0] den,
  output logic [63:0] quo
);

  localparam int N = escu_pkg::DIV_STEPS;

  logic [63:0] w   [N+1];
  logic [31:0] rem [N+1];
  logic [31:0] dv  [N+1];
  logic        neg [N+1];

  always_ff @(posedge clk) begin
    if (ce) begin
      w[0]   <= num[63] ? (64'd0 - num) : num;
      dv[0]  <= den[31] ? (32'd0 - den) : den;
      rem[0] <= '0;
      neg[0] <= num[63] ^ den[31];
    end
  end

  for (genvar i = 0; i < N; i++) begin : g_step
    logic [31:0] trial;
    logic        ge;
    assign trial = {rem[i][30:0], w[i][63]};
    assign ge    = (trial >= dv[i]);
    always_ff @(posedge clk) begin
      if (ce) begin
        rem[i+1] <= ge ? (trial - dv[i]) : trial;
        w[i+1]   <= {w[i][62:0], ge};
        dv[i+1]  <= dv[i];
        neg[i+1] <= neg[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      quo <= neg[N] ? (64'd0 - w[N]) : w[N];
    end
  end

endmodule

// File: hw/rtl/escu_regs.sv
module escu_regs (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [escu_pkg::CFG_AW-1:0]   paddr,
  input  logic [escu_pkg::CFG_DW-1:0]   pwdata,
  output logic [escu_pkg::CFG_DW-1:0]   prdata,
  output logic                          pready,
  output escu_pkg::escu_calib_t         calib
);

  escu_pkg::escu_reg_t idx;
  logic                wr;

  assign idx    = escu_pkg::escu_reg_t'(paddr[5:3]);
  assign wr     = psel & penable & pwrite;
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      calib <= '0;
    end else if (wr) begin
      case (idx)
        escu_pkg::REG_TEMP:     calib.temp    <= pwdata[47:0];
        escu_pkg::REG_PRESS_A:  calib.press_a <= pwdata;
        escu_pkg::REG_PRESS_B:  calib.press_b <= pwdata;
        escu_pkg::REG_PRESS_P9: calib.p9      <= pwdata[15:0];
        escu_pkg::REG_HUM:      calib.hum     <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      escu_pkg::REG_TEMP:     prdata = 64'(calib.temp);
      escu_pkg::REG_PRESS_A:  prdata = calib.press_a;
      escu_pkg::REG_PRESS_B:  prdata = calib.press_b;
      escu_pkg::REG_PRESS_P9: prdata = 64'(calib.p9);
      escu_pkg::REG_HUM:      prdata = calib.hum;
      default:                prdata = '0;
    endcase
  end

endmodule

// File: hw/rtl/env_sensor_compensation_unit.sv
// Integer compensation of a raw pressure / temperature / humidity triple.
// One sample is taken per clock while no result waits at the output; latency
// is set mostly by the 64-stage restoring divider of the pressure path (one
// quotient bit per stage). The whole pipeline halts while a result waits at
// the output, so nothing is dropped. The user must write the calibration
// registers over the APB port only while the stream is idle; the block does
// not enforce this. After reset they read zero and pressure reports invalid.
module env_sensor_compensation_unit (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  // raw_pressure[19:0], raw_temperature[39:20], raw_humidity[55:40]
  input  logic [escu_pkg::IN_W-1:0]     s_axis_tdata,
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  // temperature_centi[14:0], pressure_q24_8[46:15], pressure_invalid[47],
  // humidity_percent[54:48]
  output logic [escu_pkg::OUT_W-1:0]    m_axis_tdata,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [escu_pkg::CFG_AW-1:0]   paddr,
  input  logic [escu_pkg::CFG_DW-1:0]   pwdata,
  output logic [escu_pkg::CFG_DW-1:0]   prdata,
  output logic                          pready
);

  localparam int OUT_STAGE = 87;

  function automatic logic [31:0] sra32(logic [31:0] x, int n);
    return 32'($signed(x) >>> n);
  endfunction

  function automatic logic [63:0] sra64(logic [63:0] x, int n);
    return 64'($signed(x) >>> n);
  endfunction

  escu_pkg::escu_calib_t cal;

  escu_regs u_regs (
    .clk, .rst, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready,
    .calib(cal)
  );

  // coefficients
  logic [31:0] t1x, t2x, t3x;
  logic [63:0] p1x, p2x, p3x, p4x, p5x, p6x, p7x, p8x, p9x;
  logic [31:0] h1x, h2x, h3x, h4x, h5x, h6x;

  assign t1x = 32'(cal.temp[15:0]);
  assign t2x = 32'($signed(cal.temp[31:16]));
  assign t3x = 32'($signed(cal.temp[47:32]));
  assign p1x = 64'(cal.press_a[15:0]);
  assign p2x = 64'($signed(cal.press_a[31:16]));
  assign p3x = 64'($signed(cal.press_a[47:32]));
  assign p4x = 64'($signed(cal.press_a[63:48]));
  assign p5x = 64'($signed(cal.press_b[15:0]));
  assign p6x = 64'($signed(cal.press_b[31:16]));
  assign p7x = 64'($signed(cal.press_b[47:32]));
  assign p8x = 64'($signed(cal.press_b[63:48]));
  assign p9x = 64'($signed(cal.p9));
  assign h1x = 32'(cal.hum[7:0]);
  assign h2x = 32'($signed(cal.hum[23:8]));
  assign h3x = 32'(cal.hum[31:24]);
  assign h4x = 32'($signed(cal.hum[43:32]));
  assign h5x = 32'($signed(cal.hum[55:44]));
  assign h6x = 32'($signed(cal.hum[63:56]));

  // pipeline control
  logic                 ce;
  logic [OUT_STAGE:0]   vld;

  assign ce            = ~vld[OUT_STAGE] | m_axis_tready;
  assign s_axis_tready = ce;
  assign m_axis_tvalid = vld[OUT_STAGE];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (ce) begin
      vld <= {vld[OUT_STAGE-1:0], s_axis_tvalid};
    end
  end

  // stage registers
  logic [19:0] rp0, rt0;
  logic [15:0] rh0;
  logic [31:0] t_a1, t_d, t_m1, t_dd, t_v1, t_m2, tf, t_tt;
  logic [14:0] tc, t_sat;
  logic [63:0] pv1, pv2, pv1x, pnum0, pden64, px, psum, pf;
  logic [31:0] pden;
  logic        pinv;
  logic [31:0] hv, h_m5v, h_m6, h_m3, ha, h_t6, h_t3, hb0, hb, hb2, hbb;
  logic [31:0] hv2, hs, hss, hq, hr;
  logic [6:0]  hum;
  logic [31:0] t_shr;

  // delayed copies and unit outputs
  logic [63:0] sq, pm5, pm2, pv2a, pv3, pm5_9, pm2_9, ppp, pnum, pq;
  logic [63:0] py, p8q, px82, pyx, pq84, p8q84;
  logic [19:0] rp10;
  logic [15:0] rh6;
  logic [31:0] ha11, hv2_15;
  logic        pinv86;
  logic [6:0]  hum86;
  logic [14:0] tc86;

  logic [14:0] out_temp;
  logic [31:0] out_press;
  logic        out_inv;
  logic [6:0]  out_hum;

  assign t_shr  = sra32(t_tt, 8);
  assign pden64 = sra64(ppp, 33);

  always_comb begin
    if ($signed(t_shr) < escu_pkg::T_MIN) begin
      t_sat = 15'(escu_pkg::T_MIN);
    end else if ($signed(t_shr) > escu_pkg::T_MAX) begin
      t_sat = 15'(escu_pkg::T_MAX);
    end else begin
      t_sat = t_shr[14:0];
    end
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      rp0 <= s_axis_tdata[19:0];
      rt0 <= s_axis_tdata[39:20];
      rh0 <= s_axis_tdata[55:40];
      // fine temperature
      t_a1 <= 32'(rt0 >> 3) - {t1x[30:0], 1'b0};
      t_d  <= 32'(rt0 >> 4) - t1x;
      t_m1 <= t_a1 * t2x;
      t_dd <= t_d * t_d;
      t_v1 <= sra32(t_m1, 11);
      t_m2 <= sra32(t_dd, 12) * t3x;
      tf   <= t_v1 + sra32(t_m2, 14);
      t_tt <= tf * 32'd5 + 32'd128;
      tc   <= t_sat;
      // pressure
      pv1   <= 64'($signed(tf)) - 64'(escu_pkg::P_TFINE_OFS);
      pv2   <= pv2a + (pm5_9 << 17) + (p4x << 35);
      pv1x  <= escu_pkg::P_ONE_47 + sra64(pv3, 8) + (pm2_9 << 12);
      pnum0 <= ((64'(escu_pkg::P_ADC_FS) - 64'(rp10)) << 31) - pv2;
      pden  <= pden64[31:0];
      pinv  <= (pden64 == 64'd0);
      px    <= sra64(pq, 13);
      psum  <= pq84 + sra64(pyx, 25) + sra64(p8q84, 19);
      pf    <= sra64(psum, 8) + (p7x << 4);
      // humidity
      hv    <= tf - 32'(escu_pkg::H_TFINE_OFS);
      h_m5v <= h5x * hv;
      h_m6  <= hv * h6x;
      h_m3  <= hv * h3x;
      ha    <= sra32((32'(rh6) << 14) - (h4x << 20) - h_m5v
                     + 32'(escu_pkg::H_RND_A), 15);
      h_t6  <= sra32(h_m6, 10);
      h_t3  <= sra32(h_m3, 11) + 32'(escu_pkg::H_RND_B);
      hb0   <= h_t6 * h_t3;
      hb    <= sra32(hb0, 10) + 32'(escu_pkg::H_OFS_B);
      hb2   <= hb * h2x;
      hbb   <= sra32(hb2 + 32'(escu_pkg::H_RND_C), 14);
      hv2   <= ha11 * hbb;
      hs    <= sra32(hv2, 15);
      hss   <= hs * hs;
      hq    <= sra32(hss, 7) * h1x;
      hr    <= hv2_15 - sra32(hq, 4);
      if (hr[31]) begin
        hum <= 7'd0;
      end else if (hr > 32'(escu_pkg::H_MAX)) begin
        hum <= 7'(escu_pkg::H_MAX >> 22);
      end else begin
        hum <= 7'(hr >> 22);
      end
      // output register
      out_temp <= tc86;
      out_hum  <= hum86;
      out_inv  <= pinv86;
      if (pinv86 || pf[63]) begin
        out_press <= 32'd0;
      end else if (|pf[62:32]) begin
        out_press <= 32'hFFFF_FFFF;
      end else begin
        out_press <= pf[31:0];
      end
    end
  end

  assign m_axis_tdata = {1'b0, out_hum, out_inv, out_press, out_temp};

  // pressure multipliers
  escu_mul64 u_sq  (.clk, .ce, .a(pv1),   .b(pv1),  .y(sq));
  escu_mul64 u_m5  (.clk, .ce, .a(pv1),   .b(p5x),  .y(pm5));
  escu_mul64 u_m2  (.clk, .ce, .a(pv1),   .b(p2x),  .y(pm2));
  escu_mul64 u_v2a (.clk, .ce, .a(sq),    .b(p6x),  .y(pv2a));
  escu_mul64 u_v3  (.clk, .ce, .a(sq),    .b(p3x),  .y(pv3));
  escu_mul64 u_p1  (.clk, .ce, .a(pv1x),  .b(p1x),  .y(ppp));
  escu_mul64 u_sc  (.clk, .ce, .a(pnum0),
                    .b(64'(escu_pkg::P_SCALE)), .y(pnum));
  escu_mul64 u_p9  (.clk, .ce, .a(px),    .b(p9x),  .y(py));
  escu_mul64 u_p8  (.clk, .ce, .a(pq),    .b(p8x),  .y(p8q));
  escu_mul64 u_yx  (.clk, .ce, .a(py),    .b(px82), .y(pyx));

  escu_sdiv u_div (.clk, .ce, .num(pnum), .den(pden), .quo(pq));

  // alignment delays
  escu_dly #(.W(64), .DEPTH(2))  u_d_pm5  (.clk, .ce, .d(pm5),  .q(pm5_9));
  escu_dly #(.W(64), .DEPTH(2))  u_d_pm2  (.clk, .ce, .d(pm2),  .q(pm2_9));
  escu_dly #(.W(20), .DEPTH(10)) u_d_rp   (.clk, .ce, .d(rp0),  .q(rp10));
  escu_dly #(.W(64), .DEPTH(2))  u_d_px   (.clk, .ce, .d(px),   .q(px82));
  escu_dly #(.W(64), .DEPTH(5))  u_d_pq   (.clk, .ce, .d(pq),   .q(pq84));
  escu_dly #(.W(64), .DEPTH(3))  u_d_p8q  (.clk, .ce, .d(p8q),  .q(p8q84));
  escu_dly #(.W(1),  .DEPTH(73)) u_d_inv  (.clk, .ce, .d(pinv), .q(pinv86));
  escu_dly #(.W(16), .DEPTH(6))  u_d_rh   (.clk, .ce, .d(rh0),  .q(rh6));
  escu_dly #(.W(32), .DEPTH(4))  u_d_ha   (.clk, .ce, .d(ha),   .q(ha11));
  escu_dly #(.W(32), .DEPTH(3))  u_d_hv2  (.clk, .ce, .d(hv2),  .q(hv2_15));
  escu_dly #(.W(7),  .DEPTH(69)) u_d_hum  (.clk, .ce, .d(hum),  .q(hum86));
  escu_dly #(.W(15), .DEPTH(80)) u_d_tc   (.clk, .ce, .d(tc),   .q(tc86));

endmodule

// File: hw/rtl/escu_check.sv
`include "assert_macros.svh"

module escu_check (
  input logic                        clk,
  input logic                        rst,
  input logic                        s_axis_tready,
  input logic                        m_axis_tvalid,
  input logic                        m_axis_tready,
  input logic [escu_pkg::OUT_W-1:0]  m_axis_tdata
);

  `ASSERT_PROP(a_hold, clk, rst, m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
  `ASSERT_PROP(a_ready_free, clk, rst, !m_axis_tvalid |-> s_axis_tready)
  `ASSERT_NEVER(a_inv_zero, clk, rst, m_axis_tvalid && m_axis_tdata[47] && (m_axis_tdata[46:15] != 32'd0))
  `ASSERT_PROP(a_ranges, clk, rst, m_axis_tvalid |-> ($signed(m_axis_tdata[14:0]) >= -15'sd4000 && $signed(m_axis_tdata[14:0]) <= 15'sd8500 && m_axis_tdata[54:48] <= 7'd100))

endmodule

bind env_sensor_compensation_unit escu_check u_check (
  .clk(clk),
  .rst(rst),
  .s_axis_tready(s_axis_tready),
  .m_axis_tvalid(m_axis_tvalid),
  .m_axis_tready(m_axis_tready),
  .m_axis_tdata(m_axis_tdata)
);
